// ===== rtl/core/bfbp_pkg.sv =====
`default_nettype none

package bfbp_pkg;

  localparam int MAX_BINS_DEF = 64;
  localparam int SIZE_W       = 16;
  localparam int BIN_NUM_W    = 7;
  localparam int STATUS_W     = 2;

  localparam logic [SIZE_W-1:0] CAP_RESET = 16'd100;

  typedef logic [STATUS_W-1:0] status_t;

  localparam status_t ST_PACKED   = 2'd0;
  localparam status_t ST_OVERSIZE = 2'd1;
  localparam status_t ST_FULL     = 2'd2;

endpackage

`default_nettype wire

// ===== rtl/core/best_fit_bin_packer_unit.sv =====
// Best-fit bin packer. Each request carries an object size; the unit places it in the open
// bin whose remaining space is the smallest that still holds it (lowest bin number on a tie),
// or opens a new bin of cfg_wdata capacity, and returns the 1-based bin number with a status.
// Remaining space lives in one single-port-read RAM that is scanned one entry a cycle. After a
// request is accepted, the unit scans the bins opened in the current run (no scan for an
// oversized object), then decides and registers the result; the decision waits while a
// stalled result still holds the output register, and the next request is accepted only
// once the unit is idle again. One request is in work at a time. A result waits in an
// output register, and the next request is accepted while it waits. No clearing pass is
// needed after reset: a fill count bounds the scan. Write the capacity only while the unit
// is idle.
`default_nettype none

module best_fit_bin_packer_unit #(
  parameter int MAX_BINS = bfbp_pkg::MAX_BINS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_we,
  input  wire logic [bfbp_pkg::SIZE_W-1:0]       cfg_wdata,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [bfbp_pkg::SIZE_W-1:0]       in_object_size,
  input  wire logic                              in_first_object,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic      [bfbp_pkg::BIN_NUM_W-1:0]    out_bin_number,
  output logic                                   out_opened_new_bin,
  output logic      [bfbp_pkg::STATUS_W-1:0]     out_status
);

  import bfbp_pkg::*;

  localparam int AW = $clog2(MAX_BINS);
  localparam int CW = $clog2(MAX_BINS + 1);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_DECIDE = 2'd2;

  logic [1:0]           state_r, state_nxt;
  logic [SIZE_W-1:0]    cap_r, cap_nxt;
  logic [SIZE_W-1:0]    size_r, size_nxt;
  logic                 over_r, over_nxt;
  logic [CW-1:0]        count_r, count_nxt;
  logic [CW-1:0]        idx_r, idx_nxt;
  logic                 pend_r, pend_nxt;
  logic [AW-1:0]        pidx_r, pidx_nxt;
  logic                 found_r, found_nxt;
  logic [AW-1:0]        best_r, best_nxt;
  logic [SIZE_W-1:0]    best_rem_r, best_rem_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [BIN_NUM_W-1:0] out_num_r, out_num_nxt;
  logic                 out_fresh_r, out_fresh_nxt;
  status_t              out_status_r, out_status_nxt;

  logic                 mem_we;
  logic [AW-1:0]        mem_waddr;
  logic [SIZE_W-1:0]    mem_wdata;
  logic [AW-1:0]        mem_raddr;
  logic [SIZE_W-1:0]    mem_rdata;
  logic                 out_free;
  logic [CW-1:0]        best_num;
  logic [CW-1:0]        new_num;

  bfbp_ram #(
    .WIDTH (SIZE_W),
    .DEPTH (MAX_BINS)
  ) u_space_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign out_free = !out_valid_r || !out_stall;
  assign best_num = CW'(best_r) + CW'(1);
  assign new_num  = count_r + CW'(1);
  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt      = state_r;
    cap_nxt        = cfg_we ? cfg_wdata : cap_r;
    size_nxt       = size_r;
    over_nxt       = over_r;
    count_nxt      = count_r;
    idx_nxt        = idx_r;
    pend_nxt       = pend_r;
    pidx_nxt       = pidx_r;
    found_nxt      = found_r;
    best_nxt       = best_r;
    best_rem_nxt   = best_rem_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_num_nxt    = out_num_r;
    out_fresh_nxt  = out_fresh_r;
    out_status_nxt = out_status_r;
    mem_we         = 1'b0;
    mem_waddr      = best_r;
    mem_wdata      = best_rem_r - size_r;
    mem_raddr      = idx_r[AW-1:0];

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          size_nxt  = in_object_size;
          over_nxt  = in_object_size > cap_r;
          idx_nxt   = '0;
          pend_nxt  = 1'b0;
          found_nxt = 1'b0;
          if (in_first_object) begin
            count_nxt = '0;
          end
          state_nxt = (in_object_size > cap_r) ? S_DECIDE : S_SCAN;
        end
      end
      S_SCAN: begin
        if (pend_r && mem_rdata != '0 && mem_rdata >= size_r &&
            (!found_r || mem_rdata < best_rem_r)) begin
          found_nxt    = 1'b1;
          best_nxt     = pidx_r;
          best_rem_nxt = mem_rdata;
        end
        if (idx_r < count_r) begin
          idx_nxt  = idx_r + CW'(1);
          pend_nxt = 1'b1;
          pidx_nxt = idx_r[AW-1:0];
        end else begin
          pend_nxt = 1'b0;
          if (!pend_r) begin
            state_nxt = S_DECIDE;
          end
        end
      end
      S_DECIDE: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_num_nxt    = '0;
          out_fresh_nxt  = 1'b0;
          out_status_nxt = ST_PACKED;
          state_nxt      = S_IDLE;
          if (over_r) begin
            out_status_nxt = ST_OVERSIZE;
          end else if (found_r) begin
            mem_we      = 1'b1;
            out_num_nxt = BIN_NUM_W'(best_num);
          end else if (count_r == CW'(MAX_BINS)) begin
            out_status_nxt = ST_FULL;
          end else begin
            mem_we        = 1'b1;
            mem_waddr     = count_r[AW-1:0];
            mem_wdata     = cap_r - size_r;
            count_nxt     = new_num;
            out_num_nxt   = BIN_NUM_W'(new_num);
            out_fresh_nxt = 1'b1;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cap_r       <= CAP_RESET;
      count_r     <= '0;
      pend_r      <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cap_r       <= cap_nxt;
      count_r     <= count_nxt;
      pend_r      <= pend_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    size_r       <= size_nxt;
    over_r       <= over_nxt;
    idx_r        <= idx_nxt;
    pidx_r       <= pidx_nxt;
    best_r       <= best_nxt;
    best_rem_r   <= best_rem_nxt;
    out_num_r    <= out_num_nxt;
    out_fresh_r  <= out_fresh_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_bin_number     = out_num_r;
  assign out_opened_new_bin = out_fresh_r;
  assign out_status         = out_status_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_BINS))
    else $error("bin count exceeds table size");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("request accepted while previous one in work");

  a_error_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == ST_OVERSIZE || out_status == ST_FULL))
      |-> (out_bin_number == '0 && !out_opened_new_bin))
    else $error("error result carries a bin");

  a_fresh_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DECIDE && out_free && out_fresh_nxt)
      |=> (count_r == $past(count_r) + CW'(1)))
    else $error("new bin without count advance");

endmodule

`default_nettype wire

// ===== rtl/core/bfbp_ram.sv =====
`default_nettype none

module bfbp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== test/best_fit_bin_packer_unit_tb.sv =====
`timescale 1ns / 100ps

module best_fit_bin_packer_unit_tb;
  import bfbp_pkg::*;

  localparam int BIN_SLOTS   = MAX_BINS_DEF;
  localparam int STALL_LIMIT = 4000;
  localparam int HOLD_CYCLES = 480;
  localparam int SETTLE      = 80;

  typedef struct packed {
    logic [BIN_NUM_W-1:0] bin_number;
    logic                 opened_new_bin;
    status_t              status;
  } placement_t;

  typedef struct {
    logic [SIZE_W-1:0] size;
    logic              first;
    int                reps;
    bit                typed;
    placement_t        res;
  } stim_row_t;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [SIZE_W-1:0]    cfg_wdata;
  logic                 in_valid;
  logic                 in_stall;
  logic [SIZE_W-1:0]    in_object_size;
  logic                 in_first_object;
  logic                 out_valid;
  logic                 out_stall;
  logic [BIN_NUM_W-1:0] out_bin_number;
  logic                 out_opened_new_bin;
  logic [STATUS_W-1:0]  out_status;

  logic [SIZE_W-1:0] bin_room [BIN_SLOTS];
  int                bins_used;
  logic [SIZE_W-1:0] capacity;

  placement_t placement_q [$];
  int         mismatches;
  int         results_seen;
  int         burst_left;
  int         idle_cycles;

  int unsigned phase_cap [6];
  int          phase_len [6];

  stim_row_t directed_rows [23] = '{
    '{16'd0,     1'b1, 1,  1'b1, {7'd1, 1'b1, ST_PACKED}},
    '{16'd100,   1'b0, 1,  1'b1, {7'd1, 1'b0, ST_PACKED}},
    '{16'd101,   1'b0, 1,  1'b1, {7'd0, 1'b0, ST_OVERSIZE}},
    '{16'hFFFF,  1'b0, 1,  1'b1, {7'd0, 1'b0, ST_OVERSIZE}},
    '{16'd0,     1'b0, 1,  1'b0, {7'd0, 1'b0, ST_PACKED}},
    '{16'd30,    1'b0, 1,  1'b0, {7'd0, 1'b0, ST_PACKED}},
    '{16'd50,    1'b0, 1,  1'b0, {7'd0, 1'b0, ST_PACKED}},
    '{16'd40,    1'b0, 1,  1'b0, {7'd0, 1'b0, ST_PACKED}},
    '{16'd20,    1'b0, 1,  1'b0, {7'd0, 1'b0, ST_PACKED}},
    '{16'd60,    1'b0, 1,  1'b0, {7'd0, 1'b0, ST_PACKED}},
    '{16'd101,   1'b1, 1,  1'b1, {7'd0, 1'b0, ST_OVERSIZE}},
    '{16'd10,    1'b0, 1,  1'b1, {7'd1, 1'b1, ST_PACKED}},
    '{16'd10,    1'b0, 1,  1'b0, {7'd0, 1'b0, ST_PACKED}},
    '{16'd85,    1'b0, 1,  1'b0, {7'd0, 1'b0, ST_PACKED}},
    '{16'd85,    1'b0, 1,  1'b0, {7'd0, 1'b0, ST_PACKED}},
    '{16'd15,    1'b0, 1,  1'b0, {7'd0, 1'b0, ST_PACKED}},
    '{16'd0,     1'b0, 1,  1'b0, {7'd0, 1'b0, ST_PACKED}},
    '{16'd100,   1'b1, 64, 1'b0, {7'd0, 1'b0, ST_PACKED}},
    '{16'd1,     1'b0, 1,  1'b1, {7'd0, 1'b0, ST_FULL}},
    '{16'd0,     1'b0, 1,  1'b1, {7'd0, 1'b0, ST_FULL}},
    '{16'd101,   1'b0, 1,  1'b1, {7'd0, 1'b0, ST_OVERSIZE}},
    '{16'hFFFF,  1'b1, 1,  1'b1, {7'd0, 1'b0, ST_OVERSIZE}},
    '{16'd100,   1'b0, 1,  1'b1, {7'd1, 1'b1, ST_PACKED}}
  };

  best_fit_bin_packer_unit u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_object_size     (in_object_size),
    .in_first_object    (in_first_object),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_bin_number     (out_bin_number),
    .out_opened_new_bin (out_opened_new_bin),
    .out_status         (out_status)
  );

  always #6 clk = ~clk;

  function automatic placement_t pack_object(input logic [SIZE_W-1:0] size, input logic first);
    placement_t r;
    int         best;
    bit         found;
    r = '0;
    r.status = ST_PACKED;
    best = 0;
    found = 1'b0;
    if (first) begin
      foreach (bin_room[i]) bin_room[i] = '0;
      bins_used = 0;
    end
    if (size > capacity) begin
      r.status = ST_OVERSIZE;
    end else begin
      for (int b = 0; b < bins_used; b++) begin
        if (bin_room[b] != 0 && bin_room[b] >= size &&
            (!found || bin_room[b] < bin_room[best])) begin
          best = b;
          found = 1'b1;
        end
      end
      if (found) begin
        bin_room[best] = bin_room[best] - size;
        r.bin_number = BIN_NUM_W'(best + 1);
      end else if (bins_used >= BIN_SLOTS) begin
        r.status = ST_FULL;
      end else begin
        bin_room[bins_used] = capacity - size;
        bins_used++;
        r.bin_number = BIN_NUM_W'(bins_used);
        r.opened_new_bin = 1'b1;
      end
    end
    return r;
  endfunction

  function automatic logic [SIZE_W-1:0] pick_size(input logic [SIZE_W-1:0] cap);
    int unsigned k;
    k = $urandom_range(0, 99);
    if (k < 10) return SIZE_W'($urandom());
    if (k < 15) return '0;
    if (k < 22) return cap;
    if (k < 27) return (cap == '1) ? SIZE_W'($urandom()) : cap + 1'b1;
    if (k < 60) return SIZE_W'($urandom_range(0, cap));
    return SIZE_W'($urandom_range(0, cap / 4 + 1));
  endfunction

  // Call at a rising edge; returns at the edge that accepts the request.
  task automatic offer_object(input logic [SIZE_W-1:0] size, input logic first,
                              input bit typed, input placement_t typed_res);
    placement_t res;
    int         gap;
    bit         go;
    if (burst_left == 0) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: gap = 0;
        4, 5, 6, 7: gap = $urandom_range(1, 8);
        default:    gap = $urandom_range(9, 90);
      endcase
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid        <= 1'b1;
    in_object_size  <= size;
    in_first_object <= first;
    do begin
      @(negedge clk);
      go = !in_stall;
      @(posedge clk);
    end while (!go);
    res = pack_object(size, first);
    placement_q.push_back(typed ? typed_res : res);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (placement_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [SIZE_W-1:0] cap);
    cfg_we    <= 1'b1;
    cfg_wdata <= cap;
    @(posedge clk);
    cfg_we    <= 1'b0;
    capacity = cap;
    burst_left = 0;
  endtask

  always @(negedge clk) begin
    placement_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (placement_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: bin %0d new %0b status %0d",
                   out_bin_number, out_opened_new_bin, out_status);
      end else begin
        want = placement_q.pop_front();
        if (out_bin_number !== want.bin_number ||
            out_opened_new_bin !== want.opened_new_bin ||
            out_status !== want.status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result %0d: expected bin %0d new %0b status %0d, got bin %0d new %0b status %0d",
                     results_seen, want.bin_number, want.opened_new_bin, want.status,
                     out_bin_number, out_opened_new_bin, out_status);
        end
      end
    end
  end

  initial begin
    int unsigned mode;
    int          mode_left;
    int          hold_left;
    bit          held_off;
    out_stall = 1'b0;
    mode = 0;
    mode_left = 0;
    hold_left = 0;
    held_off = 1'b0;
    forever begin
      @(posedge clk);
      if (mode_left == 0) begin
        mode = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 120);
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (!held_off && results_seen >= 150) begin
        held_off = 1'b1;
        hold_left = HOLD_CYCLES;
        out_stall <= 1'b1;
      end else begin
        case (mode)
          0:       out_stall <= 1'b0;
          1:       out_stall <= ($urandom_range(0, 2) == 0);
          2:       out_stall <= (mode_left % 7 < 3);
          default: out_stall <= ($urandom_range(0, 9) < 7);
        endcase
      end
    end
  end

  initial begin
    idle_cycles = 0;
    @(posedge rst_n);
    while (idle_cycles < STALL_LIMIT) begin
      @(negedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("[best_fit_bin_packer_unit] ERROR");
    $finish;
  end

  initial begin
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_wdata       = '0;
    in_valid        = 1'b0;
    in_object_size  = '0;
    in_first_object = 1'b0;
    mismatches      = 0;
    results_seen    = 0;
    burst_left      = 0;
    foreach (bin_room[i]) bin_room[i] = '0;
    bins_used = 0;
    capacity  = CAP_RESET;
    phase_cap = '{1, 65535, 0, $urandom_range(2, 300), $urandom_range(1, 65535), 100};
    phase_len = '{110, 140, 50, 160, 140, 160};

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[r]) begin
      for (int k = 0; k < directed_rows[r].reps; k++)
        offer_object(directed_rows[r].size, directed_rows[r].first && k == 0,
                     directed_rows[r].typed, directed_rows[r].res);
    end
    drain_results();

    foreach (phase_cap[p]) begin
      write_capacity(SIZE_W'(phase_cap[p]));
      for (int n = 0; n < phase_len[p]; n++)
        offer_object(pick_size(capacity), $urandom_range(0, 49) == 0, 1'b0, '0);
      drain_results();
    end

    repeat (SETTLE) @(posedge clk);
    if (mismatches == 0 && placement_q.size() == 0)
      $display("[best_fit_bin_packer_unit] OK");
    else
      $display("[best_fit_bin_packer_unit] ERROR");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/bfbp_pkg.sv
rtl/core/bfbp_ram.sv
rtl/core/best_fit_bin_packer_unit.sv
test/best_fit_bin_packer_unit_tb.sv
